// ===== hdl/mbfr_pkg.sv =====
// Shared codes and constants for the MSB-first bit field reader.
package mbfr_pkg;
  localparam int unsigned BufBytesDefault = 256;

  localparam logic [2:0] OpLoad    = 3'd0;
  localparam logic [2:0] OpRead    = 3'd1;
  localparam logic [2:0] OpSkip    = 3'd2;
  localparam logic [2:0] OpAlign   = 3'd3;
  localparam logic [2:0] OpRestart = 3'd4;

  localparam logic [2:0] FmtUns  = 3'd0;
  localparam logic [2:0] FmtTwos = 3'd1;
  localparam logic [2:0] FmtBcd  = 3'd2;
  localparam logic [2:0] FmtSbcd = 3'd3;
  localparam logic [2:0] FmtSmag = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StInvalid  = 2'd1;
  localparam logic [1:0] StUnderrun = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;
endpackage

// ===== hdl/mbfr_ram.sv =====
// Generic single-port RAM with registered read.
module mbfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hdl/msb_first_bit_field_reader.sv =====
// Streaming MSB-first bit field reader. Load items append a byte to a BufBytes-deep buffer;
// read items take a 0 to 64 bit field from the bit cursor, most significant bit first, and
// decode it as unsigned, two's complement, BCD, signed BCD or sign-magnitude; skip, align and
// restart items move or clear the cursor, and restart also empties the buffer. Every input
// item gives exactly one result item, and a new item is accepted only after the previous
// result has been taken. Loads, skips, restarts, aligns by 0 or 1 and rejected reads finish
// directly from the execute state. A read that spans k buffer bytes (k up to 9) takes one byte
// per cycle from the single RAM port, with a wait state after each byte change; BCD formats
// then decode one digit per step. An align to a boundary b above 1 steps through the multiples
// of b until one reaches the byte position. The input is ready again in the cycle after the
// result is taken.
module msb_first_bit_field_reader #(
  parameter int unsigned BufBytes = mbfr_pkg::BufBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], byte_in[10:3], bit_count[17:11], format[20:18], amount[32:21]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // value[63:0], status[65:64], bits_left[77:66]
  output logic [79:0] m_axis_tdata
);
  localparam int unsigned Aw = $clog2(BufBytes);
  localparam int unsigned Cw = $clog2(BufBytes + 1);
  localparam int unsigned Pw = Cw + 3;
  localparam int unsigned Ew = Pw + 13;
  localparam int unsigned Mw = Cw + 13;

  typedef enum logic [2:0] {
    SIdle, SExec, SBits, SDigit, SAlign, SDone
  } state_e;

  state_e        state_q;
  logic [2:0]    op_q, fmt_q;
  logic [7:0]    byte_q;
  logic [6:0]    cnt_q, left_q;
  logic [11:0]   amt_q;
  logic [Cw-1:0] fill_q, bcur_q;
  logic [2:0]    bitc_q;
  logic [63:0]   raw_q, acc_q, val_q;
  logic [4:0]    dig_q;
  logic          neg_q, rd_wait_q;
  logic [1:0]    st_q;
  logic [Mw-1:0] mult_q;
  logic          ram_we;
  logic [Aw-1:0] ram_addr;
  logic [7:0]    ram_rd;
  logic [Pw-1:0] rem;
  logic [Ew-1:0] pos_end;
  logic [Cw:0]   apos;
  logic          bad_w;
  logic [3:0]    avail;
  logic [3:0]    take;
  logic [7:0]    sh;
  logic [3:0]    nib;
  logic [5:0]    msb_idx;
  logic          raw_msb;
  logic [63:0]   low_mask, ext_mask;
  logic [6:0]    bcd_bits;

  assign rem = (bcur_q >= fill_q) ? '0
             : ({fill_q - bcur_q, 3'b000} - Pw'(bitc_q));

  always_comb begin
    unique case (fmt_q)
      mbfr_pkg::FmtUns, mbfr_pkg::FmtTwos: bad_w = cnt_q > 7'd64;
      mbfr_pkg::FmtBcd:  bad_w = cnt_q > 7'd64 || cnt_q[1:0] != 2'd0;
      mbfr_pkg::FmtSbcd: bad_w = cnt_q < 7'd5 || cnt_q[1:0] != 2'd1 || cnt_q > 7'd61;
      mbfr_pkg::FmtSmag: bad_w = cnt_q > 7'd64 || cnt_q < 7'd2;
      default: bad_w = 1'b1;
    endcase
  end

  assign ram_we   = state_q == SExec && op_q == mbfr_pkg::OpLoad && fill_q < Cw'(BufBytes);
  assign ram_addr = (state_q == SExec && op_q == mbfr_pkg::OpLoad) ? fill_q[Aw-1:0]
                                                                   : bcur_q[Aw-1:0];

  mbfr_ram #(.Width(8), .Depth(BufBytes)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(byte_q), .rdata_o(ram_rd)
  );

  // bits taken from the current byte this cycle
  assign avail = 4'd8 - {1'b0, bitc_q};
  assign take  = ({1'b0, left_q} < {4'b0, avail}) ? left_q[3:0] : avail;
  assign sh    = ram_rd << bitc_q;
  assign nib   = acc_q[63:60];

  assign msb_idx  = cnt_q[5:0] - 6'd1;
  assign raw_msb  = raw_q[msb_idx];
  assign low_mask = (64'd1 << msb_idx) - 64'd1;
  assign ext_mask = ~(low_mask | (64'd1 << msb_idx));
  assign bcd_bits = (fmt_q == mbfr_pkg::FmtBcd) ? cnt_q : (cnt_q - 7'd1);

  assign apos    = {1'b0, bcur_q} + (Cw+1)'(bitc_q != 3'd0);
  assign pos_end = Ew'({bcur_q, bitc_q}) + Ew'(amt_q);

  assign s_axis_tready = state_q == SIdle;
  assign m_axis_tvalid = state_q == SDone;
  assign m_axis_tdata  = {2'b00, 12'(rem), st_q, val_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      op_q      <= '0;
      fmt_q     <= '0;
      byte_q    <= '0;
      cnt_q     <= '0;
      left_q    <= '0;
      amt_q     <= '0;
      fill_q    <= '0;
      bcur_q    <= '0;
      bitc_q    <= '0;
      raw_q     <= '0;
      acc_q     <= '0;
      val_q     <= '0;
      dig_q     <= '0;
      neg_q     <= 1'b0;
      rd_wait_q <= 1'b0;
      st_q      <= mbfr_pkg::StOk;
      mult_q    <= '0;
    end else begin
      unique case (state_q)
        SIdle: if (s_axis_tvalid) begin
          op_q    <= s_axis_tdata[2:0];
          byte_q  <= s_axis_tdata[10:3];
          cnt_q   <= s_axis_tdata[17:11];
          fmt_q   <= s_axis_tdata[20:18];
          amt_q   <= s_axis_tdata[32:21];
          state_q <= SExec;
        end
        SExec: begin
          val_q   <= '0;
          st_q    <= mbfr_pkg::StOk;
          state_q <= SDone;
          unique case (op_q)
            mbfr_pkg::OpLoad:
              if (fill_q >= Cw'(BufBytes)) st_q <= mbfr_pkg::StFull;
              else fill_q <= fill_q + Cw'(1);
            mbfr_pkg::OpRead:
              if (bad_w) st_q <= mbfr_pkg::StInvalid;
              else if (cnt_q == 7'd0) st_q <= mbfr_pkg::StOk;
              else if (Ew'(rem) < Ew'(cnt_q)) st_q <= mbfr_pkg::StUnderrun;
              else begin
                left_q    <= cnt_q;
                raw_q     <= '0;
                rd_wait_q <= 1'b0;
                state_q   <= SBits;
              end
            mbfr_pkg::OpSkip:
              if (Ew'(amt_q) > Ew'(rem)) st_q <= mbfr_pkg::StUnderrun;
              else begin
                bcur_q <= pos_end[Pw-1:3];
                bitc_q <= pos_end[2:0];
              end
            mbfr_pkg::OpAlign:
              if (amt_q == 12'd1) begin
                bcur_q <= apos[Cw-1:0];
                bitc_q <= '0;
              end else if (amt_q != 12'd0) begin
                mult_q  <= '0;
                state_q <= SAlign;
              end
            mbfr_pkg::OpRestart: begin
              fill_q <= '0;
              bcur_q <= '0;
              bitc_q <= '0;
            end
            default: st_q <= mbfr_pkg::StInvalid;
          endcase
        end
        SBits: begin
          // RAM read data is registered behind the address, so wait after each byte change
          if (left_q != 7'd0) begin
            if (rd_wait_q) begin
              rd_wait_q <= 1'b0;
            end else begin
              raw_q  <= (raw_q << take) | 64'(sh >> (4'd8 - take));
              left_q <= left_q - 7'(take);
              if ({1'b0, bitc_q} + take == 4'd8) begin
                bcur_q    <= bcur_q + Cw'(1);
                bitc_q    <= '0;
                rd_wait_q <= 1'b1;
              end else begin
                bitc_q <= bitc_q + take[2:0];
              end
            end
          end else begin
            neg_q <= raw_msb;
            unique case (fmt_q)
              mbfr_pkg::FmtUns: begin
                val_q   <= raw_q;
                state_q <= SDone;
              end
              mbfr_pkg::FmtTwos: begin
                val_q   <= raw_msb ? (raw_q | ext_mask) : raw_q;
                state_q <= SDone;
              end
              mbfr_pkg::FmtSmag: begin
                val_q   <= raw_msb ? (64'd0 - (raw_q & low_mask)) : (raw_q & low_mask);
                state_q <= SDone;
              end
              default: begin
                dig_q   <= 5'(bcd_bits >> 2);
                acc_q   <= raw_q << (7'd64 - bcd_bits);
                raw_q   <= '0;
                state_q <= SDigit;
              end
            endcase
          end
        end
        SDigit: begin
          if (dig_q != 5'd0) begin
            if (nib > 4'd9) begin
              st_q    <= mbfr_pkg::StInvalid;
              val_q   <= '0;
              state_q <= SDone;
            end else begin
              raw_q <= (raw_q << 3) + (raw_q << 1) + 64'(nib);
              acc_q <= acc_q << 4;
              dig_q <= dig_q - 5'd1;
            end
          end else begin
            val_q   <= (fmt_q == mbfr_pkg::FmtSbcd && neg_q) ? 64'd0 - raw_q : raw_q;
            state_q <= SDone;
          end
        end
        SAlign: begin
          // step through multiples of the boundary until one reaches the position
          if (mult_q >= Mw'(apos)) begin
            bcur_q  <= (mult_q >= Mw'(fill_q)) ? fill_q : mult_q[Cw-1:0];
            bitc_q  <= '0;
            state_q <= SDone;
          end else begin
            mult_q <= mult_q + Mw'(amt_q);
          end
        end
        SDone: if (m_axis_tready) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== hdl/mbfr_checker.sv =====
// Port-level assertions for the bit field reader, bound to the top level.
module mbfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepts while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_ok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[65:64] != 2'd0 |-> m_axis_tdata[63:0] == 64'd0)
    else $error("error item with value");
  a_no_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early result");
endmodule

bind msb_first_bit_field_reader mbfr_checker u_mbfr_checker (.*);
